// ===== rtl/core/rtd_pkg.sv =====
package rtd_pkg;

   // Field widths
   localparam int ADDRESS_OCTETS = 6;
   localparam int ADDR_W         = 8 * ADDRESS_OCTETS;
   localparam int RSSI_W         = 8;
   localparam int CHAN_W         = 8;
   localparam int MARGIN_W       = 8;
   localparam int REASON_W       = 2;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = ADDR_W;

   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic signed [RSSI_W-1:0]   rssi_type;
   typedef logic [CHAN_W-1:0]          chan_type;
   typedef logic [MARGIN_W-1:0]        margin_type;

   // Decision reason codes
   typedef enum logic [REASON_W-1:0] {
      REASON_NONE       = 2'd0,
      REASON_IMMINENT   = 2'd1,
      REASON_SUGGESTED  = 2'd2,
      REASON_LOW_SIGNAL = 2'd3
   } reason_type;

   // Register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SERVING_BSSID     = 3'd0,
      CSR_SERVING_RSSI      = 3'd1,
      CSR_RSSI_THRESHOLD    = 3'd2,
      CSR_HYSTERESIS_MARGIN = 3'd3,
      CSR_REQ_PRESENT       = 3'd4,
      CSR_REQ_IMMINENT      = 3'd5,
      CSR_REQ_HAS_PREF      = 3'd6,
      CSR_PREFERRED_BSSID   = 3'd7
   } csr_index_type;

   localparam rssi_type   RSSI_THRESHOLD_RESET = -8'sd75;
   localparam margin_type MARGIN_RESET         = 8'd8;

   // Running scan state
   typedef struct packed {
      logic     found;
      rssi_type rssi;
      addr_type address;
      chan_type chan;
   } best_type;

   typedef struct packed {
      logic     found;
      rssi_type rssi;
      chan_type chan;
   } pref_type;

endpackage

// ===== rtl/core/rtd_intf.sv =====
// Candidate item channel
interface rtd_req_if import rtd_pkg::*;;
   logic     valid;
   logic     ready;
   logic     candidate_valid;
   addr_type candidate_bssid;
   rssi_type candidate_rssi;
   chan_type candidate_channel;
   logic     last_candidate;

   modport source (output valid, candidate_valid, candidate_bssid, candidate_rssi,
                   candidate_channel, last_candidate, input ready);
   modport sink   (input valid, candidate_valid, candidate_bssid, candidate_rssi,
                   candidate_channel, last_candidate, output ready);
endinterface

// Decision item channel
interface rtd_rsp_if import rtd_pkg::*;;
   logic                valid;
   logic                ready;
   logic                roam;
   addr_type            roam_bssid;
   chan_type            roam_channel;
   logic [REASON_W-1:0] decision_reason;

   modport source (output valid, roam, roam_bssid, roam_channel, decision_reason,
                   input ready);
   modport sink   (input valid, roam, roam_bssid, roam_channel, decision_reason,
                   output ready);
endinterface

// Register write channel
interface rtd_csr_if import rtd_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/roam_target_decision.sv =====
// Roam target decision.
// Candidate access points stream in on req_chan, one item each, the list closed
// by an item with last_candidate set (candidate_valid low marks an item that
// carries no candidate, e.g. the end of an empty list). Each list yields one
// decision item on rsp_chan: roam flag, target address and channel, and reason.
// Registers are written on csr_chan (always ready); the user must write them only
// while the block is idle, which the block itself does not enforce. A closing item
// passes the input register, then the scan update and decision logic that loads the
// result register. Throughput: one item per cycle while rsp_chan does not stall.
// Reset clears the pipeline, the scan state and the registers to their defaults
// (threshold -75 dBm, margin 8 dB, all else zero).
// When rsp_chan stalls with a decision waiting, the input register still takes
// one more item; after that req_chan.ready drops until the decision is taken.
module roam_target_decision import rtd_pkg::*; (
   input logic        clock,
   input logic        reset,
   rtd_req_if.sink    req_chan,
   rtd_rsp_if.source  rsp_chan,
   rtd_csr_if.sink    csr_chan
);

   // Configuration registers
   addr_type   serving_bssid_ff;
   rssi_type   serving_rssi_ff;
   rssi_type   rssi_threshold_ff;
   margin_type margin_ff;
   logic       req_present_ff;
   logic       req_imminent_ff;
   logic       req_has_pref_ff;
   addr_type   preferred_bssid_ff;

   // Input register
   logic     in_valid_ff;
   logic     in_cand_ff;
   addr_type in_bssid_ff;
   rssi_type in_rssi_ff;
   chan_type in_chan_ff;
   logic     in_last_ff;

   // Scan state
   best_type best_ff, best_in;
   pref_type pref_ff, pref_in;

   // Result register
   logic       out_valid_ff;
   logic       out_roam_ff, out_roam_in;
   addr_type   out_bssid_ff, out_bssid_in;
   chan_type   out_chan_ff, out_chan_in;
   reason_type out_reason_ff, out_reason_in;

   logic advance, fire, req_accept;
   logic best_take, pref_take;
   logic signed [RSSI_W+1:0] best_wide, need_wide;

   assign csr_chan.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         serving_bssid_ff   <= '0;
         serving_rssi_ff    <= '0;
         rssi_threshold_ff  <= RSSI_THRESHOLD_RESET;
         margin_ff          <= MARGIN_RESET;
         req_present_ff     <= 1'b0;
         req_imminent_ff    <= 1'b0;
         req_has_pref_ff    <= 1'b0;
         preferred_bssid_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.addr))
            CSR_SERVING_BSSID:     serving_bssid_ff   <= csr_chan.data[ADDR_W-1:0];
            CSR_SERVING_RSSI:      serving_rssi_ff    <= csr_chan.data[RSSI_W-1:0];
            CSR_RSSI_THRESHOLD:    rssi_threshold_ff  <= csr_chan.data[RSSI_W-1:0];
            CSR_HYSTERESIS_MARGIN: margin_ff          <= csr_chan.data[MARGIN_W-1:0];
            CSR_REQ_PRESENT:       req_present_ff     <= csr_chan.data[0];
            CSR_REQ_IMMINENT:      req_imminent_ff    <= csr_chan.data[0];
            CSR_REQ_HAS_PREF:      req_has_pref_ff    <= csr_chan.data[0];
            CSR_PREFERRED_BSSID:   preferred_bssid_ff <= csr_chan.data[ADDR_W-1:0];
         endcase
      end
   end

   // Handshake: the whole pipe moves when the result register can take data
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign fire           = in_valid_ff && advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cand_ff  <= req_chan.candidate_valid;
         in_bssid_ff <= req_chan.candidate_bssid;
         in_rssi_ff  <= req_chan.candidate_rssi;
         in_chan_ff  <= req_chan.candidate_channel;
         in_last_ff  <= req_chan.last_candidate;
      end
   end

   // Fold the current item into the running best and preferred entries
   always_comb begin
      best_take = in_cand_ff && (in_bssid_ff != serving_bssid_ff) &&
                  (!best_ff.found || ($signed(in_rssi_ff) > $signed(best_ff.rssi)));
      pref_take = in_cand_ff && !pref_ff.found && (in_bssid_ff == preferred_bssid_ff);
      best_in   = best_ff;
      pref_in   = pref_ff;
      if (best_take) begin
         best_in = '{found: 1'b1, rssi: in_rssi_ff, address: in_bssid_ff, chan: in_chan_ff};
      end
      if (pref_take) begin
         pref_in = '{found: 1'b1, rssi: in_rssi_ff, chan: in_chan_ff};
      end
   end

   // Low-signal lead test, widened by two bits so the sum cannot wrap
   assign best_wide = {{2{best_in.rssi[RSSI_W-1]}}, best_in.rssi};
   assign need_wide = $signed({{2{serving_rssi_ff[RSSI_W-1]}}, serving_rssi_ff}) +
                      $signed({2'b00, margin_ff});

   // Decision rules in priority order
   always_comb begin
      out_roam_in   = 1'b0;
      out_bssid_in  = '0;
      out_chan_in   = '0;
      out_reason_in = REASON_NONE;
      priority if (req_present_ff && req_imminent_ff) begin
         if (req_has_pref_ff && pref_in.found) begin
            out_roam_in   = 1'b1;
            out_bssid_in  = preferred_bssid_ff;
            out_chan_in   = pref_in.chan;
            out_reason_in = REASON_IMMINENT;
         end else if (best_in.found) begin
            out_roam_in   = 1'b1;
            out_bssid_in  = best_in.address;
            out_chan_in   = best_in.chan;
            out_reason_in = REASON_IMMINENT;
         end
      end else if (req_present_ff && req_has_pref_ff && pref_in.found &&
                   ($signed(pref_in.rssi) >= $signed(serving_rssi_ff))) begin
         out_roam_in   = 1'b1;
         out_bssid_in  = preferred_bssid_ff;
         out_chan_in   = pref_in.chan;
         out_reason_in = REASON_SUGGESTED;
      end else if (best_in.found &&
                   ($signed(serving_rssi_ff) <= $signed(rssi_threshold_ff)) &&
                   (best_wide >= need_wide)) begin
         out_roam_in   = 1'b1;
         out_bssid_in  = best_in.address;
         out_chan_in   = best_in.chan;
         out_reason_in = REASON_LOW_SIGNAL;
      end else begin
         // stay
         out_reason_in = REASON_NONE;
      end
   end

   // Scan state: updated per item, cleared after each decision
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
         pref_ff <= '0;
      end else if (fire) begin
         if (in_last_ff) begin
            best_ff <= '0;
            pref_ff <= '0;
         end else begin
            best_ff <= best_in;
            pref_ff <= pref_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         out_roam_ff   <= out_roam_in;
         out_bssid_ff  <= out_bssid_in;
         out_chan_ff   <= out_chan_in;
         out_reason_ff <= out_reason_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.roam            = out_roam_ff;
   assign rsp_chan.roam_bssid      = out_bssid_ff;
   assign rsp_chan.roam_channel    = out_chan_ff;
   assign rsp_chan.decision_reason = out_reason_ff;

endmodule

// ===== rtl/core/rtd_checker.sv =====
module rtd_checker import rtd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                roam,
   input addr_type            roam_bssid,
   input chan_type            roam_channel,
   input logic [REASON_W-1:0] decision_reason
);

   // A waiting decision holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({roam, roam_bssid, roam_channel, decision_reason}))
      else $error("decision item changed while stalled");

   // Staying decisions carry an empty target
   a_stay_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !roam |-> roam_bssid == '0 && roam_channel == '0)
      else $error("stay decision with nonzero target");

   // Roam flag and reason agree
   a_roam_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> roam == (decision_reason != REASON_NONE))
      else $error("roam flag does not match reason");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("decision pending after reset");

endmodule

bind roam_target_decision rtd_checker u_rtd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .roam            (rsp_chan.roam),
   .roam_bssid      (rsp_chan.roam_bssid),
   .roam_channel    (rsp_chan.roam_channel),
   .decision_reason (rsp_chan.decision_reason)
);
